FILE: hw/rtl/aiss_pkg.sv
`default_nettype none

package aiss_pkg;

	localparam int DATA_W    = 32;
	localparam int KIND_W    = 3;
	localparam int POS_W     = 6;
	localparam int STATUS_W  = 2;
	localparam int FOUND_W   = 6;
	localparam int CNT_OUT_W = 7;

	// operation codes
	localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SORT   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_INSERT,
		ST_SEARCH,
		ST_SORT_INIT,
		ST_SORT_PASS,
		ST_DONE
	} aiss_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/aiss_if.sv
`default_nettype none

interface aiss_cmd_if
	import aiss_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic signed [DATA_W-1:0] value;
	logic [POS_W-1:0]         position;

	modport source (output valid, output kind, output value, output position, input ready);
	modport sink (input valid, input kind, input value, input position, output ready);
endinterface

interface aiss_rsp_if
	import aiss_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic [FOUND_W-1:0]       found_index;
	logic signed [DATA_W-1:0] read_value;
	logic [CNT_OUT_W-1:0]     entry_count;

	modport source (output valid, output status, output found_index, output read_value,
		output entry_count, input ready);
	modport sink (input valid, input status, input found_index, input read_value,
		input entry_count, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/aiss_ram.sv
`default_nettype none

module aiss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read-first on a same-address collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/array_insert_search_sort_engine_top.sv
// one transaction at a time: the next command is taken once the result sits in the output
// register, so the one read and one write port set the pace; append, a full table, a read
// out of range, a sort of under two entries and unused kinds finish straight from idle;
// read waits on one table read, search scans up from index 0, insert moves entries up from
// the top to the middle, and sort runs bubble passes
// reset: arst_n clears count and control; the table stays uncleared, read only below count
`default_nettype none

module array_insert_search_sort_engine_top
	import aiss_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	aiss_cmd_if.sink    cmd,
	aiss_rsp_if.source  rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	// width for comparing the read position against the count
	localparam int XW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	// control state
	aiss_state_t state_q, state_d;
	logic [CW-1:0] valid_count_q, valid_count_d;
	logic [CW-1:0] ptr_q, ptr_d;        // insert destination, search scan, sort read index
	logic [CW-1:0] lim_q, lim_d;        // last index of the current bubble pass
	logic          pend_s1, pend_d;     // a table read is in flight
	logic [CW-1:0] idx_s1, idx_d;       // index of the read in flight
	logic          out_valid_q, out_valid_d;

	// payload
	logic [DATA_W-1:0]   key_q, key_d;
	logic [DATA_W-1:0]   carry_q, carry_d;   // largest value so far in a bubble pass
	logic [STATUS_W-1:0] res_status_q, res_status_d;
	logic [FOUND_W-1:0]  res_found_q, res_found_d;
	logic [DATA_W-1:0]   res_rdata_q, res_rdata_d;
	logic [STATUS_W-1:0] out_status_q;
	logic [FOUND_W-1:0]  out_found_q;
	logic [DATA_W-1:0]   out_rdata_q;
	logic [CNT_OUT_W-1:0] out_count_q;
	logic                out_load;

	// table port
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	logic          cmd_accept;
	logic [CW-1:0] mid;
	logic [CW-1:0] idx_dec;
	logic          search_hit;
	logic          carry_gt;

	assign cmd.ready  = (state_q == ST_IDLE);
	assign cmd_accept = cmd.valid && cmd.ready;

	assign mid        = valid_count_q >> 1;
	assign idx_dec    = idx_s1 - CW'(1);
	assign search_hit = pend_s1 && (ram_rdata == key_q);
	assign carry_gt   = $signed(carry_q) > $signed(ram_rdata);

	aiss_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			valid_count_q <= '0;
			ptr_q         <= '0;
			lim_q         <= '0;
			pend_s1       <= 1'b0;
			idx_s1        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			valid_count_q <= valid_count_d;
			ptr_q         <= ptr_d;
			lim_q         <= lim_d;
			pend_s1       <= pend_d;
			idx_s1        <= idx_d;
			out_valid_q   <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q        <= key_d;
		carry_q      <= carry_d;
		res_status_q <= res_status_d;
		res_found_q  <= res_found_d;
		res_rdata_q  <= res_rdata_d;
		if (out_load) begin
			out_status_q <= res_status_q;
			out_found_q  <= res_found_q;
			out_rdata_q  <= res_rdata_q;
			out_count_q  <= CNT_OUT_W'(valid_count_q);
		end
	end

	always_comb begin
		state_d       = state_q;
		valid_count_d = valid_count_q;
		ptr_d         = ptr_q;
		lim_d         = lim_q;
		pend_d        = 1'b0;
		idx_d         = idx_s1;
		key_d         = key_q;
		carry_d       = carry_q;
		res_status_d  = res_status_q;
		res_found_d   = res_found_q;
		res_rdata_d   = res_rdata_q;
		out_load      = 1'b0;
		out_valid_d   = out_valid_q && !rsp.ready;
		ram_we        = 1'b0;
		ram_waddr     = '0;
		ram_wdata     = '0;
		ram_raddr     = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (cmd_accept) begin
					key_d        = cmd.value;
					res_status_d = STAT_OK;
					res_found_d  = '0;
					res_rdata_d  = '0;
					state_d      = ST_DONE;
					unique case (cmd.kind)
						KIND_APPEND: begin
							if (valid_count_q >= FULL_CNT) begin
								res_status_d = STAT_FULL;
							end else begin
								ram_we        = 1'b1;
								ram_waddr     = valid_count_q[AW-1:0];
								ram_wdata     = cmd.value;
								valid_count_d = valid_count_q + CW'(1);
							end
						end
						KIND_INSERT: begin
							if (valid_count_q >= FULL_CNT) begin
								res_status_d = STAT_FULL;
							end else begin
								ptr_d   = valid_count_q;
								state_d = ST_INSERT;
							end
						end
						KIND_SEARCH: begin
							ptr_d   = '0;
							state_d = ST_SEARCH;
						end
						KIND_SORT: begin
							if (valid_count_q >= CW'(2)) begin
								lim_d   = valid_count_q - CW'(1);
								state_d = ST_SORT_INIT;
							end
						end
						KIND_READ: begin
							if (XW'(cmd.position) >= XW'(valid_count_q)) begin
								res_status_d = STAT_RANGE;
							end else begin
								ram_raddr = AW'(cmd.position);
								state_d   = ST_READ;
							end
						end
						default: begin
							// unused kinds: plain ok result, table untouched
						end
					endcase
				end
			end

			ST_READ: begin
				res_rdata_d = ram_rdata;
				state_d     = ST_DONE;
			end

			ST_INSERT: begin
				// move entries up one place, from the top down to the middle
				if (pend_s1) begin
					ram_we    = 1'b1;
					ram_waddr = idx_s1[AW-1:0];
					ram_wdata = ram_rdata;
				end
				if (ptr_q > mid) begin
					ram_raddr = AW'(ptr_q - CW'(1));
					pend_d    = 1'b1;
					idx_d     = ptr_q;
					ptr_d     = ptr_q - CW'(1);
				end else if (!pend_s1) begin
					ram_we        = 1'b1;
					ram_waddr     = mid[AW-1:0];
					ram_wdata     = key_q;
					valid_count_d = valid_count_q + CW'(1);
					state_d       = ST_DONE;
				end
			end

			ST_SEARCH: begin
				if (search_hit) begin
					res_found_d = FOUND_W'(idx_s1);
					state_d     = ST_DONE;
				end else if (ptr_q == valid_count_q) begin
					res_status_d = STAT_NOTFOUND;
					state_d      = ST_DONE;
				end else begin
					ram_raddr = ptr_q[AW-1:0];
					pend_d    = 1'b1;
					idx_d     = ptr_q;
					ptr_d     = ptr_q + CW'(1);
				end
			end

			ST_SORT_INIT: begin
				ram_raddr = '0;
				pend_d    = 1'b1;
				idx_d     = '0;
				ptr_d     = CW'(1);
				state_d   = ST_SORT_PASS;
			end

			ST_SORT_PASS: begin
				// carry the larger value up, write the smaller one back one place lower
				if (pend_s1) begin
					if (idx_s1 == '0) begin
						carry_d = ram_rdata;
					end else begin
						ram_we    = 1'b1;
						ram_waddr = idx_dec[AW-1:0];
						ram_wdata = carry_gt ? ram_rdata : carry_q;
						carry_d   = carry_gt ? carry_q : ram_rdata;
					end
				end
				if (ptr_q <= lim_q) begin
					ram_raddr = ptr_q[AW-1:0];
					pend_d    = 1'b1;
					idx_d     = ptr_q;
					ptr_d     = ptr_q + CW'(1);
				end else if (!pend_s1) begin
					ram_we    = 1'b1;
					ram_waddr = lim_q[AW-1:0];
					ram_wdata = carry_q;
					lim_d     = lim_q - CW'(1);
					state_d   = (lim_q == CW'(1)) ? ST_DONE : ST_SORT_INIT;
				end
			end

			ST_DONE: begin
				// hand over once the output register is free or being emptied
				if (!out_valid_q || rsp.ready) begin
					out_load    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.found_index = out_found_q;
	assign rsp.read_value  = out_rdata_q;
	assign rsp.entry_count = out_count_q;

	// count never passes the table size
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_count_q <= FULL_CNT)
	else $error("entry count above table size");

	// the count only holds or grows by one
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (valid_count_q == $past(valid_count_q)) ||
			(valid_count_q == $past(valid_count_q) + CW'(1)))
	else $error("entry count moved by more than one");

	// no table write while idle without a new transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !cmd_accept) |-> !ram_we)
	else $error("table written while idle");

	// a bubble pass stays inside the valid entries
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SORT_PASS) |-> (lim_q < valid_count_q) && (lim_q != '0))
	else $error("sort pass limit outside the table");

	// a search hit lies below the count
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH && search_hit) |-> (idx_s1 < valid_count_q))
	else $error("search hit beyond the count");

endmodule

`default_nettype wire

FILE: dv/aiss_tb_pkg.sv
`timescale 1ns / 1ps

package aiss_tb_pkg;
	import aiss_pkg::*;

	localparam int TABLE_DEPTH = 64;

	// kinds that the block ignores
	localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic [FOUND_W-1:0]       found_index;
		logic signed [DATA_W-1:0] read_value;
		logic [CNT_OUT_W-1:0]     entry_count;
	} table_result_t;

	class table_tracker;
		logic signed [DATA_W-1:0] shadow [TABLE_DEPTH];
		int                       shadow_count;
		table_result_t            due_results [$];
		int                       errors;

		function new();
			shadow_count = 0;
			errors = 0;
		endfunction

		// shadow the table and queue the outcome of one accepted command
		function void note_op(logic [KIND_W-1:0] kind, logic signed [DATA_W-1:0] value,
				logic [POS_W-1:0] position);
			table_result_t            res;
			int                       i;
			int                       mid;
			int                       pass;
			bit                       hit;
			logic signed [DATA_W-1:0] swap;
			res = '0;
			case (kind)
				KIND_APPEND: begin
					if (shadow_count >= TABLE_DEPTH) begin
						res.status = STAT_FULL;
					end else begin
						shadow[shadow_count] = value;
						shadow_count++;
					end
				end
				KIND_INSERT: begin
					if (shadow_count >= TABLE_DEPTH) begin
						res.status = STAT_FULL;
					end else begin
						mid = shadow_count / 2;
						for (i = shadow_count; i > mid; i--)
							shadow[i] = shadow[i-1];
						shadow[mid] = value;
						shadow_count++;
					end
				end
				KIND_SEARCH: begin
					res.status = STAT_NOTFOUND;
					hit = 1'b0;
					for (i = 0; i < shadow_count && !hit; i++) begin
						if (shadow[i] == value) begin
							hit = 1'b1;
							res.status = STAT_OK;
							res.found_index = i[FOUND_W-1:0];
						end
					end
				end
				KIND_SORT: begin
					for (pass = 0; pass + 1 < shadow_count; pass++) begin
						for (i = 0; i + 1 < shadow_count - pass; i++) begin
							if (shadow[i] > shadow[i+1]) begin
								swap = shadow[i];
								shadow[i] = shadow[i+1];
								shadow[i+1] = swap;
							end
						end
					end
				end
				KIND_READ: begin
					if (int'(position) >= shadow_count)
						res.status = STAT_RANGE;
					else
						res.read_value = shadow[position];
				end
				default: ;
			endcase
			res.entry_count = shadow_count[CNT_OUT_W-1:0];
			due_results.push_back(res);
		endfunction

		function void check_result(table_result_t got);
			table_result_t want;
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: status %0d found %0d read %0d count %0d",
						got.status, got.found_index, got.read_value, got.entry_count);
				return;
			end
			want = due_results.pop_front();
			if (got.status != want.status || got.found_index != want.found_index ||
					got.read_value != want.read_value || got.entry_count != want.entry_count) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: expected status %0d found %0d read %0d count %0d,",
						" got status %0d found %0d read %0d count %0d"},
						want.status, want.found_index, want.read_value, want.entry_count,
						got.status, got.found_index, got.read_value, got.entry_count);
			end
		endfunction
	endclass

endpackage

FILE: dv/tb_array_insert_search_sort_engine_top.sv
`timescale 1ns / 1ps

module tb_array_insert_search_sort_engine_top;
	import aiss_pkg::*;
	import aiss_tb_pkg::*;

	// random commands that the block acts on (spare kinds are extra)
	localparam int RANDOM_OPS = 1600;
	// longest quiet stretch, long enough for a full-table sort
	localparam int IDLE_LIMIT = 20000;
	// trailing cycles to catch a stray result after the last one
	localparam int SETTLE_CYCLES = 200;
	// drain the block every so many random commands
	localparam int DRAIN_EVERY = 400;

	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	logic clk;
	logic arst_n;
	bit   steady;
	int   quiet;

	table_tracker board;

	aiss_cmd_if cmd ();
	aiss_rsp_if rsp ();

	array_insert_search_sort_engine_top #(
		.DEPTH(TABLE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd.sink),
		.rsp(rsp.source)
	);

	// 20 ns clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// idle length for either side: mostly none or short, now and then long,
	// and none at all while a steady stretch runs
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// operand mix: full-range words, a narrow band for duplicates and near misses,
	// the extremes, and words already in the table so searches hit
	function automatic logic signed [DATA_W-1:0] pick_value();
		int r;
		int near;
		r = $urandom_range(0, 99);
		near = int'($urandom_range(0, 16)) - 8;
		if (r < 30)
			return $urandom;
		if (r < 60)
			return near;
		if (r < 70) begin
			case ($urandom_range(0, 3))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return '0;
				default: return '1;
			endcase
		end
		if (board.shadow_count > 0)
			return board.shadow[$urandom_range(0, board.shadow_count - 1)];
		return $urandom;
	endfunction

	// keep valid low for the given number of cycles before the next command
	task automatic hold_off(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			cmd.valid <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	// one command transaction: optional gap, drive at the falling edge,
	// hold until the block takes it, then shadow it in the tracker
	task automatic issue(input logic [KIND_W-1:0] kind, input logic signed [DATA_W-1:0] value,
			input logic [POS_W-1:0] position);
		hold_off(pick_gap());
		@(negedge clk);
		cmd.valid    <= 1'b1;
		cmd.kind     <= kind;
		cmd.value    <= value;
		cmd.position <= position;
		do @(posedge clk); while (!cmd.ready);
		board.note_op(kind, value, position);
	endtask

	// sender stands still until every outstanding result is back
	task automatic drain();
		@(negedge clk);
		cmd.valid <= 1'b0;
		while (board.due_results.size() != 0) @(negedge clk);
	endtask

	// short directed run: empty-table cases, insert at the middle, the extremes,
	// duplicate keys, reads at and past the count, sort and the ignored kinds
	task automatic run_directed();
		issue(KIND_SEARCH, 32'sd5, 6'd0);        // search on an empty table
		issue(KIND_READ, '0, 6'd0);              // read with no entries
		issue(KIND_SORT, '0, 6'd0);              // sort with nothing in it
		issue(KIND_INSERT, 32'sd7, 6'd0);        // insert on an empty table lands at 0
		issue(KIND_SORT, '0, 6'd63);             // sort with a single entry
		issue(KIND_APPEND, VAL_MAX, 6'd0);
		issue(KIND_APPEND, VAL_MIN, 6'd0);
		issue(KIND_INSERT, '0, 6'd0);
		issue(KIND_APPEND, '1, 6'd0);
		issue(KIND_INSERT, 32'sd1, 6'd0);
		issue(KIND_APPEND, '0, 6'd0);            // duplicate of an earlier entry
		issue(KIND_SEARCH, '0, 6'd0);            // must give the lower of the two
		issue(KIND_SEARCH, '1, 6'd0);
		issue(KIND_SEARCH, 32'sd12345, 6'd0);    // miss on a filled table
		issue(KIND_SEARCH, VAL_MIN, 6'd0);
		issue(KIND_READ, '0, 6'd63);             // far past the count
		issue(KIND_READ, '0, 6'd6);              // last valid entry
		issue(KIND_READ, '0, 6'd7);              // exactly at the count
		issue(KIND_SORT, '0, 6'd0);              // signed order puts the minimum first
		issue(KIND_READ, '0, 6'd0);
		issue(KIND_READ, '0, 6'd6);
		issue(KIND_SEARCH, VAL_MAX, 6'd0);
		issue(KIND_SPARE_FIRST, $urandom, 6'($urandom));
		issue(3'd6, $urandom, 6'($urandom));
		issue(KIND_SPARE_LAST, $urandom, 6'($urandom));
	endtask

	// random run: writes are kept rare so the table fills slowly and every fill
	// level sees searches, reads and sorts; once full, writes report full
	task automatic run_random();
		int                       counted;
		int                       r;
		logic [KIND_W-1:0]        kind;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
		counted = 0;
		while (counted < RANDOM_OPS) begin
			// every fifth block of a hundred runs without idling on either side
			steady = ((counted / 100) % 5) == 2;
			r = $urandom_range(0, 99);
			if (r < 2)
				kind = KIND_W'($urandom_range(int'(KIND_SPARE_FIRST), int'(KIND_SPARE_LAST)));
			else if (r < 5)
				kind = KIND_APPEND;
			else if (r < 8)
				kind = KIND_INSERT;
			else if (r < 16)
				kind = KIND_SORT;
			else if (r < 56)
				kind = KIND_SEARCH;
			else
				kind = KIND_READ;
			value = pick_value();
			// reads mostly land inside the table, the rest anywhere
			if (kind == KIND_READ && board.shadow_count > 0 && $urandom_range(0, 99) < 80)
				position = POS_W'($urandom_range(0, board.shadow_count - 1));
			else
				position = POS_W'($urandom);
			issue(kind, value, position);
			if (kind <= KIND_READ) begin
				counted++;
				if (counted % DRAIN_EVERY == 0)
					drain();
			end
		end
		steady = 1'b0;
	endtask

	// result side: ready held high for a run, then dropped for a gap
	initial begin
		int run;
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			run = steady ? 50 : $urandom_range(1, 8);
			stall = pick_gap();
			@(negedge clk);
			rsp.ready <= 1'b1;
			repeat (run - 1) @(negedge clk);
			if (stall > 0) begin
				@(negedge clk);
				rsp.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
		end
	end

	// result monitor, sampled at the rising edge
	always @(posedge clk) begin
		table_result_t got;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.status      = rsp.status;
			got.found_index = rsp.found_index;
			got.read_value  = rsp.read_value;
			got.entry_count = rsp.entry_count;
			board.check_result(got);
		end
	end

	// watchdog: too long without a transaction on either side ends the run
	always @(posedge clk) begin
		if (!arst_n || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= IDLE_LIMIT) begin
				$display("tb_array_insert_search_sort_engine_top: errors");
				$finish;
			end
		end
	end

	initial begin
		board        = new();
		steady       = 1'b0;
		quiet        = 0;
		arst_n       = 1'b0;
		cmd.valid    = 1'b0;
		cmd.kind     = '0;
		cmd.value    = '0;
		cmd.position = '0;
		rsp.ready    = 1'b0;

		// reset held low from the start, released once
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		run_directed();
		drain();
		run_random();

		// last transaction taken: wait for the tail, then a quiet spell
		@(negedge clk);
		cmd.valid <= 1'b0;
		while (board.due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (board.errors == 0 && board.due_results.size() == 0) begin
			$display("tb_array_insert_search_sort_engine_top: clean");
		end else begin
			$display("tb_array_insert_search_sort_engine_top: errors");
		end
		$finish;
	end

endmodule
